### rtl/core/bwt_pkg.sv
// Shared types and codes for the breakpoint/watchpoint table.
// Used by bwt_cell, breakpoint_watchpoint_table_top and tb_top; no dependencies.
package bwt_pkg;

	// command modes as they arrive on the input stream
	localparam logic [1:0] MODE_CHECK  = 2'd0;
	localparam logic [1:0] MODE_ADD    = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;

	// entry kinds
	localparam logic [1:0] KIND_INSN  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;
	localparam logic [1:0] KIND_RW    = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_PRESENT = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_MISSING = 3'd3;
	localparam logic [2:0] ST_BADKIND = 3'd4;

	// operation broadcast to every cell of the row
	typedef enum logic [1:0] {
		OP_NONE,
		OP_CHECK,
		OP_ADD,
		OP_REMOVE
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] kind;
	} cmd_t;

	// priority link passed from each cell to the next higher one
	typedef struct packed {
		logic free_seen;   // a lower cell is free
		logic exact_seen;  // a lower cell holds the exact range and kind
	} link_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_OP_A,
		S_OP_B,
		S_HOLD
	} state_t;

endpackage

### rtl/core/breakpoint_watchpoint_table_top.sv
// Top level of the breakpoint/watchpoint table: stream ports, sequencer,
// result register and the row of bwt_cell slots. Depends on bwt_pkg.
//
//  channel  | direction | transfer when          | payload
//  ---------+-----------+------------------------+------------------------------------
//  s_*      | in        | s_tvalid && s_tready   | tuser: mode, kind; tdata: start, end
//  m_*      | out       | m_tvalid && m_tready   | tdata: hit, match_mask; tuser: status
//
// A command passes through S_OP_A and then S_HOLD before the next input transfer (with
// S_OP_B between them for add or remove of the read-and-write kind, which runs the write
// and read entries as two passes through the cell row); its result is registered at each
// pass and moved into the output register from S_HOLD. One command is in flight.
// Reset clears all valid bits at once; no clearing pass.
// The input side is ready again once the result has moved into the output
// register, so a stalled output holds off at most one further command.
module breakpoint_watchpoint_table_top
	import bwt_pkg::*;
#(
	parameter int ENTRIES   = 16,
	parameter int ADDR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] addr_start, [31:16] range_end
	input  logic [3:0]  s_tuser,   // [1:0] mode, [3:2] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [0] hit, [16:1] match_mask, [23:17] zero
	output logic [2:0]  m_tuser    // [2:0] status
);

	localparam int MASK_BITS = 16;

	state_t state_q;
	state_t state_nx;

	logic [1:0]           mode_q;
	logic [1:0]           kind_q;
	logic [ADDR_BITS-1:0] start_q;
	logic [ADDR_BITS-1:0] end_q;
	logic [2:0]           st_a_q;

	logic                 res_hit_q;
	logic [MASK_BITS-1:0] res_mask_q;
	logic [2:0]           res_status_q;

	logic                 m_valid_q;
	logic                 m_hit_q;
	logic [MASK_BITS-1:0] m_mask_q;
	logic [2:0]           m_status_q;

	cmd_t                 cmd;
	logic [2:0]           stat_cur;
	logic [2:0]           stat_fin;
	logic                 two_pass;
	logic                 exact_any;
	logic                 free_any;
	logic [ENTRIES-1:0]   match_w;
	logic [MASK_BITS-1:0] mask_w;
	link_t                link_w [ENTRIES+1];

	// row of slot cells
	assign link_w[0] = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		bwt_cell #(
			.ADDR_BITS(ADDR_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.addr_s    (start_q),
			.addr_e    (end_q),
			.exact_any (exact_any),
			.link_in   (link_w[i]),
			.link_out  (link_w[i+1]),
			.match     (match_w[i])
		);
	end

	assign exact_any = link_w[ENTRIES].exact_seen;
	assign free_any  = link_w[ENTRIES].free_seen;

	// only the first sixteen slots have a mask bit
	for (genvar i = 0; i < MASK_BITS; i++) begin : g_mask
		if (i < ENTRIES) begin : g_on
			assign mask_w[i] = match_w[i];
		end else begin : g_off
			assign mask_w[i] = 1'b0;
		end
	end

	assign two_pass = (mode_q inside {MODE_ADD, MODE_REMOVE}) && (kind_q == KIND_RW);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_nx = S_OP_A;
				end
			end
			S_OP_A: begin
				state_nx = two_pass ? S_OP_B : S_HOLD;
			end
			S_OP_B: begin
				state_nx = S_HOLD;
			end
			S_HOLD: begin
				if (!m_valid_q || m_tready) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// cell command and status of the current pass
	always_comb begin
		cmd.op   = OP_NONE;
		cmd.kind = kind_q;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
			end
			S_OP_A: begin
				case (mode_q)
					MODE_CHECK: begin
						cmd.op = (kind_q == KIND_RW) ? OP_NONE : OP_CHECK;
					end
					MODE_ADD: begin
						cmd.op = OP_ADD;
					end
					MODE_REMOVE: begin
						cmd.op = OP_REMOVE;
					end
					default: begin
						cmd.op = OP_NONE;
					end
				endcase
				if (kind_q == KIND_RW) begin
					cmd.kind = KIND_WRITE;
				end
			end
			S_OP_B: begin
				cmd.op   = (mode_q == MODE_ADD) ? OP_ADD : OP_REMOVE;
				cmd.kind = KIND_READ;
			end
			default: begin
				cmd.op = OP_NONE;
			end
		endcase

		case (mode_q)
			MODE_CHECK:  stat_cur = (kind_q == KIND_RW) ? ST_BADKIND : ST_OK;
			MODE_ADD:    stat_cur = exact_any ? ST_PRESENT : (free_any ? ST_OK : ST_FULL);
			MODE_REMOVE: stat_cur = exact_any ? ST_OK : ST_MISSING;
			default:     stat_cur = ST_OK;
		endcase

		// merge of the write and read passes
		stat_fin = ST_OK;
		if (mode_q == MODE_ADD) begin
			if ((st_a_q == ST_FULL) || (stat_cur == ST_FULL)) begin
				stat_fin = ST_FULL;
			end else if ((st_a_q == ST_PRESENT) && (stat_cur == ST_PRESENT)) begin
				stat_fin = ST_PRESENT;
			end
		end else if ((st_a_q == ST_MISSING) && (stat_cur == ST_MISSING)) begin
			stat_fin = ST_MISSING;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_HOLD && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// command capture, pass results and output register
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_q  <= s_tuser[1:0];
			kind_q  <= s_tuser[3:2];
			start_q <= ADDR_BITS'(s_tdata[15:0]);
			end_q   <= ADDR_BITS'(s_tdata[31:16]);
		end
		if (state_q == S_OP_A) begin
			st_a_q       <= stat_cur;
			res_hit_q    <= |match_w;
			res_mask_q   <= mask_w;
			res_status_q <= stat_cur;
		end
		if (state_q == S_OP_B) begin
			res_status_q <= stat_fin;
		end
		if (state_q == S_HOLD && (!m_valid_q || m_tready)) begin
			m_hit_q    <= res_hit_q;
			m_mask_q   <= res_mask_q;
			m_status_q <= res_status_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, m_mask_q, m_hit_q};
	assign m_tuser  = m_status_q;

endmodule

### rtl/core/bwt_cell.sv
// One table slot: valid bit, range and kind, with its local compares.
// Depends on bwt_pkg; chained by breakpoint_watchpoint_table_top.
module bwt_cell
	import bwt_pkg::*;
#(
	parameter int ADDR_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	input  logic [ADDR_BITS-1:0] addr_s,     // range start, or accessed address
	input  logic [ADDR_BITS-1:0] addr_e,
	input  logic                 exact_any,  // exact entry somewhere in the row
	input  link_t                link_in,
	output link_t                link_out,
	output logic                 match
);

	logic                 valid_q;
	logic [ADDR_BITS-1:0] start_q;
	logic [ADDR_BITS-1:0] end_q;
	logic [1:0]           kind_q;

	logic is_exact;
	logic is_free;
	logic take;
	logic drop;

	// local compares
	always_comb begin
		is_exact = valid_q && (start_q == addr_s) && (end_q == addr_e) &&
			(kind_q == cmd.kind);
		is_free  = !valid_q;
		match    = (cmd.op == OP_CHECK) && valid_q && (kind_q == cmd.kind) &&
			(addr_s >= start_q) && (addr_s <= end_q);
	end

	// lowest free cell takes an add unless an exact entry exists; lowest exact cell takes a remove
	always_comb begin
		take = (cmd.op == OP_ADD) && !exact_any && is_free && !link_in.free_seen;
		drop = (cmd.op == OP_REMOVE) && is_exact && !link_in.exact_seen;
		link_out.free_seen  = link_in.free_seen | is_free;
		link_out.exact_seen = link_in.exact_seen | is_exact;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (drop) begin
			valid_q <= 1'b0;
		end
	end

	// payload, meaningful only while valid
	always_ff @(posedge clk) begin
		if (take) begin
			start_q <= addr_s;
			end_q   <= addr_e;
			kind_q  <= cmd.kind;
		end
	end

endmodule

### verif/tb_top.sv
// Self-checking testbench for breakpoint_watchpoint_table_top: a directed table, then random
// add/remove/check traffic checked against a mirror of the trap table.
// Depends on bwt_pkg and the top-level RTL only.
module tb_top
	import bwt_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD   = 4;
	localparam int SLOTS        = 16;
	localparam int ITEMS        = 1850;
	localparam int POOL         = 20;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_AT      = 700;   // results seen before the long output hold-off
	localparam int HOLD_CYCLES  = 400;

	// mode code the block must ignore
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic        hit;
		logic [15:0] match_mask;
		logic [2:0]  status;
	} watch_result_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [1:0]  kind;
		logic [15:0] start_addr;
		logic [15:0] end_addr;
	} trap_cmd_t;

	typedef struct packed {
		trap_cmd_t     cmd;
		logic          typed;  // 1: use the expected value below as written
		watch_result_t want;
	} dir_row_t;

	localparam int NUM_DIRECTED = 24;

	// table state after the last row: slot 0 insn 0000-ffff, slot 1 insn 5555-aaaa,
	// slot 3 write 8000-7fff (inverted range)
	localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
		// empty table, bad kind, ignored mode, remove of nothing
		'{'{MODE_CHECK,  KIND_INSN,  16'h0000, 16'h0000}, 1'b1, '{1'b0, 16'h0000, ST_OK}},
		'{'{MODE_CHECK,  KIND_RW,    16'hffff, 16'hffff}, 1'b1, '{1'b0, 16'h0000, ST_BADKIND}},
		'{'{MODE_UNUSED, KIND_RW,    16'hffff, 16'hffff}, 1'b1, '{1'b0, 16'h0000, ST_OK}},
		'{'{MODE_REMOVE, KIND_INSN,  16'h0000, 16'hffff}, 1'b1, '{1'b0, 16'h0000, ST_MISSING}},
		// full address range, duplicate add
		'{'{MODE_ADD,    KIND_INSN,  16'h0000, 16'hffff}, 1'b1, '{1'b0, 16'h0000, ST_OK}},
		'{'{MODE_ADD,    KIND_INSN,  16'h0000, 16'hffff}, 1'b1, '{1'b0, 16'h0000, ST_PRESENT}},
		'{'{MODE_CHECK,  KIND_INSN,  16'hffff, 16'h0000}, 1'b1, '{1'b1, 16'h0001, ST_OK}},
		'{'{MODE_CHECK,  KIND_WRITE, 16'hffff, 16'h0000}, 1'b1, '{1'b0, 16'h0000, ST_OK}},
		// read-and-write pair lands in slots 1 and 2
		'{'{MODE_ADD,    KIND_RW,    16'h1000, 16'h10ff}, 1'b1, '{1'b0, 16'h0000, ST_OK}},
		'{'{MODE_CHECK,  KIND_WRITE, 16'h10ff, 16'h0000}, 1'b1, '{1'b1, 16'h0002, ST_OK}},
		'{'{MODE_CHECK,  KIND_READ,  16'h1000, 16'h0000}, 1'b1, '{1'b1, 16'h0004, ST_OK}},
		'{'{MODE_CHECK,  KIND_READ,  16'h0fff, 16'h0000}, 1'b1, '{1'b0, 16'h0000, ST_OK}},
		'{'{MODE_ADD,    KIND_RW,    16'h1000, 16'h10ff}, 1'b1, '{1'b0, 16'h0000, ST_PRESENT}},
		// start above end is stored but never matches
		'{'{MODE_ADD,    KIND_WRITE, 16'h8000, 16'h7fff}, 1'b1, '{1'b0, 16'h0000, ST_OK}},
		'{'{MODE_CHECK,  KIND_WRITE, 16'h8000, 16'h0000}, 1'b1, '{1'b0, 16'h0000, ST_OK}},
		'{'{MODE_ADD,    KIND_READ,  16'h1000, 16'h10ff}, 1'b1, '{1'b0, 16'h0000, ST_PRESENT}},
		// partial read-and-write add/remove
		'{'{MODE_REMOVE, KIND_READ,  16'h1000, 16'h10ff}, 1'b1, '{1'b0, 16'h0000, ST_OK}},
		'{'{MODE_ADD,    KIND_RW,    16'h1000, 16'h10ff}, 1'b1, '{1'b0, 16'h0000, ST_OK}},
		'{'{MODE_REMOVE, KIND_RW,    16'h1000, 16'h10ff}, 1'b1, '{1'b0, 16'h0000, ST_OK}},
		'{'{MODE_REMOVE, KIND_RW,    16'h1000, 16'h10ff}, 1'b1, '{1'b0, 16'h0000, ST_MISSING}},
		// overlapping ranges; remaining rows go through the mirror
		'{'{MODE_ADD,    KIND_INSN,  16'h5555, 16'haaaa}, 1'b1, '{1'b0, 16'h0000, ST_OK}},
		'{'{MODE_CHECK,  KIND_INSN,  16'h5555, 16'h0000}, 1'b0, '0},
		'{'{MODE_UNUSED, KIND_INSN,  16'h8000, 16'h7fff}, 1'b0, '0},
		'{'{MODE_CHECK,  KIND_WRITE, 16'h7fff, 16'hffff}, 1'b0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [3:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;

	// mirror of the trap table
	logic        mirror_valid [SLOTS];
	logic [15:0] mirror_lo [SLOTS];
	logic [15:0] mirror_hi [SLOTS];
	logic [1:0]  mirror_kind [SLOTS];

	watch_result_t pending_watch_results [$];
	int            mismatch_count = 0;
	int            results_seen = 0;

	// range pool shared by add, remove and check so that they collide
	logic [15:0] pool_lo [POOL];
	logic [15:0] pool_hi [POOL];

	always #(CLK_PERIOD / 2) clk = ~clk;

	breakpoint_watchpoint_table_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// lowest valid slot holding exactly this range and kind, or -1
	function automatic int find_slot(logic [15:0] lo, logic [15:0] hi, logic [1:0] k);
		for (int i = 0; i < SLOTS; i++) begin
			if (mirror_valid[i] && mirror_lo[i] == lo && mirror_hi[i] == hi &&
			    mirror_kind[i] == k)
				return i;
		end
		return -1;
	endfunction

	function automatic logic [2:0] insert_slot(logic [15:0] lo, logic [15:0] hi,
			logic [1:0] k);
		if (find_slot(lo, hi, k) >= 0)
			return ST_PRESENT;
		for (int i = 0; i < SLOTS; i++) begin
			if (!mirror_valid[i]) begin
				mirror_valid[i] = 1'b1;
				mirror_lo[i]    = lo;
				mirror_hi[i]    = hi;
				mirror_kind[i]  = k;
				return ST_OK;
			end
		end
		return ST_FULL;
	endfunction

	function automatic logic [2:0] delete_slot(logic [15:0] lo, logic [15:0] hi,
			logic [1:0] k);
		int idx;
		idx = find_slot(lo, hi, k);
		if (idx < 0)
			return ST_MISSING;
		mirror_valid[idx] = 1'b0;
		return ST_OK;
	endfunction

	// apply one command to the mirror and return the result it must produce
	function automatic watch_result_t trap_table_apply(trap_cmd_t c);
		watch_result_t r;
		logic [2:0]    st_w;
		logic [2:0]    st_r;
		r = '0;
		case (c.mode)
			MODE_CHECK: begin
				if (c.kind == KIND_RW) begin
					r.status = ST_BADKIND;
				end else begin
					for (int i = 0; i < SLOTS; i++) begin
						if (mirror_valid[i] && mirror_kind[i] == c.kind &&
						    c.start_addr >= mirror_lo[i] && c.start_addr <= mirror_hi[i]) begin
							r.hit = 1'b1;
							r.match_mask[i] = 1'b1;
						end
					end
				end
			end
			MODE_ADD: begin
				if (c.kind == KIND_RW) begin
					st_w = insert_slot(c.start_addr, c.end_addr, KIND_WRITE);
					st_r = insert_slot(c.start_addr, c.end_addr, KIND_READ);
					if (st_w == ST_FULL || st_r == ST_FULL)
						r.status = ST_FULL;
					else if (st_w == ST_PRESENT && st_r == ST_PRESENT)
						r.status = ST_PRESENT;
					else
						r.status = ST_OK;
				end else begin
					r.status = insert_slot(c.start_addr, c.end_addr, c.kind);
				end
			end
			MODE_REMOVE: begin
				if (c.kind == KIND_RW) begin
					st_w = delete_slot(c.start_addr, c.end_addr, KIND_WRITE);
					st_r = delete_slot(c.start_addr, c.end_addr, KIND_READ);
					r.status = (st_w == ST_MISSING && st_r == ST_MISSING) ? ST_MISSING : ST_OK;
				end else begin
					r.status = delete_slot(c.start_addr, c.end_addr, c.kind);
				end
			end
			default: ;  // unused mode: no effect
		endcase
		return r;
	endfunction

	// idle length: mostly none or short, a few long
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	task automatic refill_pool();
		int sel;
		for (int p = 0; p < POOL; p++) begin
			pool_lo[p] = 16'($urandom_range(0, 16'hffff));
			sel = $urandom_range(0, 9);
			if (sel < 7)
				pool_hi[p] = pool_lo[p] + 16'($urandom_range(0, 255));
			else if (sel == 7)
				pool_hi[p] = pool_lo[p];
			else if (sel == 8)
				pool_hi[p] = pool_lo[p] - 16'($urandom_range(1, 100));
			else
				pool_hi[p] = 16'($urandom_range(0, 16'hffff));
		end
	endtask

	// random command; style biases the mode mix (0 fill, 1 check, 2 drain, 3 even)
	function automatic trap_cmd_t random_cmd(int style);
		trap_cmd_t c;
		int        r;
		int        add_t;
		int        chk_t;
		int        p;
		logic [15:0] span;
		case (style)
			0:       begin add_t = 55; chk_t = 85; end
			1:       begin add_t = 15; chk_t = 85; end
			2:       begin add_t = 15; chk_t = 45; end
			default: begin add_t = 33; chk_t = 66; end
		endcase
		r = $urandom_range(0, 99);
		if (r < add_t)
			c.mode = MODE_ADD;
		else if (r < chk_t)
			c.mode = MODE_CHECK;
		else if (r < 97)
			c.mode = MODE_REMOVE;
		else
			c.mode = MODE_UNUSED;
		c.kind = 2'($urandom_range(0, 3));
		c.start_addr = 16'($urandom_range(0, 16'hffff));
		c.end_addr = 16'($urandom_range(0, 16'hffff));
		p = $urandom_range(0, POOL - 1);
		if (c.mode == MODE_CHECK) begin
			// probe the edges of a known range most of the time
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 4))
					0: c.start_addr = pool_lo[p] - 16'd1;
					1: c.start_addr = pool_lo[p];
					2: c.start_addr = pool_hi[p];
					3: c.start_addr = pool_hi[p] + 16'd1;
					default: begin
						span = pool_hi[p] - pool_lo[p];
						c.start_addr = (pool_lo[p] <= pool_hi[p]) ?
							pool_lo[p] + 16'($urandom_range(0, span)) : pool_lo[p];
					end
				endcase
			end
		end else if ($urandom_range(0, 9) != 0) begin
			c.start_addr = pool_lo[p];
			c.end_addr = pool_hi[p];
		end
		return c;
	endfunction

	// offer one command and wait for its transfer; returns at a falling edge
	task automatic offer_cmd(trap_cmd_t c, logic typed, watch_result_t want);
		watch_result_t r;
		s_tdata  <= {c.end_addr, c.start_addr};
		s_tuser  <= {c.kind, c.mode};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		r = trap_table_apply(c);
		pending_watch_results.push_back(typed ? want : r);
		@(negedge clk);
	endtask

	task automatic sender_gap(bit quiet);
		int n;
		n = quiet ? 0 : idle_cycles();
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// always moves on by at least one falling edge
	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (pending_watch_results.size() != 0);
	endtask

	// stimulus
	initial begin
		int sent;
		int phase;
		int plen;
		for (int i = 0; i < SLOTS; i++) begin
			mirror_valid[i] = 1'b0;
			mirror_lo[i]    = '0;
			mirror_hi[i]    = '0;
			mirror_kind[i]  = KIND_INSN;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			offer_cmd(DIRECTED[i].cmd, DIRECTED[i].typed, DIRECTED[i].want);
			sender_gap(1'b0);
		end
		wait_results_drained();

		// random phases, each ending with a pause until all results are back
		sent = NUM_DIRECTED;
		phase = 0;
		while (sent < ITEMS) begin
			if (phase % 4 == 0)
				refill_pool();
			plen = $urandom_range(80, 200);
			for (int k = 0; k < plen && sent < ITEMS; k++) begin
				offer_cmd(random_cmd(phase % 4), 1'b0, '0);
				sent++;
				sender_gap(phase % 3 == 2);
			end
			wait_results_drained();
			phase++;
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_watch_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// result side: check each transfer, then pick the next ready value
	initial begin
		watch_result_t want;
		int            stall_left;
		int            calm_left;
		int            hold_left;
		bit            held;
		stall_left = 0;
		calm_left  = 0;
		hold_left  = 0;
		held       = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (pending_watch_results.size() == 0) begin
					$display("%0t: unexpected result hit=%b mask=%h status=%0d", $realtime,
						m_tdata[0], m_tdata[16:1], m_tuser);
					mismatch_count++;
				end else begin
					want = pending_watch_results.pop_front();
					if (m_tdata[0] !== want.hit) begin
						$display("%0t: hit expected %b got %b", $realtime, want.hit, m_tdata[0]);
						mismatch_count++;
					end
					if (m_tdata[16:1] !== want.match_mask) begin
						$display("%0t: match_mask expected %h got %h", $realtime,
							want.match_mask, m_tdata[16:1]);
						mismatch_count++;
					end
					if (m_tuser !== want.status) begin
						$display("%0t: status expected %0d got %0d", $realtime,
							want.status, m_tuser);
						mismatch_count++;
					end
				end
				results_seen++;
				if (results_seen == HOLD_AT && !held) begin
					hold_left = HOLD_CYCLES;
					held = 1'b1;
				end
			end
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (calm_left > 0) begin
				calm_left--;
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 9) == 0) begin
				calm_left = $urandom_range(20, 120);
				m_tready <= 1'b1;
			end else begin
				stall_left = idle_cycles();
				m_tready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// watchdog: too long without any transfer on either side
	initial begin
		int idle_count;
		idle_count = 0;
		while (idle_count < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_count = 0;
			else
				idle_count++;
		end
		$display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
